FILE: design/lkds_pkg.sv
// ----------------------------------------------------------------------------
// lkds_pkg
// Shared types and constants for the leapfrog kick/drift step.
// ----------------------------------------------------------------------------
package lkds_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned UWORD_W = 31;
  localparam int unsigned LANES = 3;
  localparam logic [UWORD_W-1:0] TIME_STEP_RESET = 31'd655;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

  typedef enum logic {
    OP_KICK  = 1'b0,
    OP_DRIFT = 1'b1
  } op_t;

  // Per-request control that travels down the pipeline with the data.
  typedef struct packed {
    op_t  op;
    logic zm;
  } ctl_t;

endpackage

FILE: design/leapfrog_kick_drift_step.sv
// ----------------------------------------------------------------------------
// leapfrog_kick_drift_step
// Fully pipelined kick/drift integrator step for one body per request.
// ----------------------------------------------------------------------------
// One request is taken in every cycle (busy stays low). Its result is
// registered at the end of the pipeline and strobed by done for one cycle;
// the receiver cannot hold results off. The force / mass divider resolves
// one quotient bit per stage over 32 + FRAC_BITS stages for each axis; every
// request passes through it, kick or drift, so results leave in request
// order. Write time_step only while no request is in flight.
module leapfrog_kick_drift_step #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [30:0]           cfg_data,
  input  lkds_pkg::op_t         opcode,
  input  logic signed [31:0]    pos_x,
  input  logic signed [31:0]    pos_y,
  input  logic signed [31:0]    pos_z,
  input  logic signed [31:0]    vel_x,
  input  logic signed [31:0]    vel_y,
  input  logic signed [31:0]    vel_z,
  input  logic signed [31:0]    force_x,
  input  logic signed [31:0]    force_y,
  input  logic signed [31:0]    force_z,
  input  logic [30:0]           mass,
  output logic                  done,
  output logic signed [31:0]    new_pos_x,
  output logic signed [31:0]    new_pos_y,
  output logic signed [31:0]    new_pos_z,
  output logic signed [31:0]    new_vel_x,
  output logic signed [31:0]    new_vel_y,
  output logic signed [31:0]    new_vel_z,
  output logic                  zero_mass
);
  import lkds_pkg::*;

  localparam int unsigned DW   = WORD_W + FRAC_BITS;  // dividend / quotient width
  localparam int unsigned ST_A = DW + 1;              // saturate, pick operand
  localparam int unsigned ST_B = DW + 2;              // multiply
  localparam int unsigned ST_C = DW + 3;              // scale toward zero
  localparam int unsigned NST  = DW + 4;
  localparam int unsigned LAT  = DW + 5;
  localparam int unsigned SH_K = FRAC_BITS + 1;

  logic [UWORD_W-1:0] time_step;

  logic                      vld   [NST];
  ctl_t                      ctl   [NST];
  logic signed [WORD_W-1:0]  pos_p [NST][LANES];
  logic signed [WORD_W-1:0]  vel_p [NST][LANES];
  logic [UWORD_W-1:0]        mass_p[DW+1];
  logic                      sgn_p [DW+1][LANES];
  logic [DW-1:0]             dq    [DW+1][LANES];
  logic [UWORD_W-1:0]        rem   [DW+1][LANES];
  logic [DW-1:0]             dq_next [DW+1][LANES];
  logic [UWORD_W-1:0]        rem_next[DW+1][LANES];

  logic signed [WORD_W-1:0]  opa   [LANES];
  logic signed [63:0]        prod  [LANES];
  logic signed [63:0]        dlt   [LANES];
  logic signed [63:0]        dlt_next[LANES];
  logic signed [WORD_W-1:0]  acc_next[LANES];
  logic signed [WORD_W-1:0]  sum_sat[LANES];

  logic signed [WORD_W-1:0]  in_pos[LANES];
  logic signed [WORD_W-1:0]  in_vel[LANES];
  logic signed [WORD_W-1:0]  in_frc[LANES];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  assign in_pos = '{pos_x, pos_y, pos_z};
  assign in_vel = '{vel_x, vel_y, vel_z};
  assign in_frc = '{force_x, force_y, force_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TIME_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      time_step <= cfg_data;
    end
  end

  // Restoring divider, one quotient bit per stage; dividend shifts out of dq
  // while quotient bits shift in.
  for (genvar s = 1; s <= DW; s++) begin : g_div
    for (genvar k = 0; k < LANES; k++) begin : g_lane
      logic [WORD_W-1:0] trial;
      logic              ge;
      assign trial = {rem[s-1][k], dq[s-1][k][DW-1]};
      assign ge    = trial >= {1'b0, mass_p[s-1]};
      always_comb begin
        if (ge) begin
          rem_next[s][k] = UWORD_W'(trial - {1'b0, mass_p[s-1]});
        end else begin
          rem_next[s][k] = trial[UWORD_W-1:0];
        end
        dq_next[s][k] = {dq[s-1][k][DW-2:0], ge};
      end
    end
  end
  assign dq_next[0]  = '{default: '0};
  assign rem_next[0] = '{default: '0};

  // Saturate the quotient, then pick the multiplicand for kick or drift.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      logic [DW-1:0] q;
      logic          ovf_p;
      logic          ovf_n;
      q     = dq[DW][k];
      ovf_p = |q[DW-1:WORD_W-1];
      ovf_n = (|q[DW-1:WORD_W]) || (q[WORD_W-1] && (|q[WORD_W-2:0]));
      if (sgn_p[DW][k]) begin
        acc_next[k] = ovf_n ? WORD_MIN : -$signed(q[WORD_W-1:0]);
      end else begin
        acc_next[k] = ovf_p ? WORD_MAX : $signed(q[WORD_W-1:0]);
      end
    end
  end

  // Divide the product by a power of two, truncating toward zero.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      logic signed [63:0] bias_k;
      logic signed [63:0] bias_d;
      bias_k = prod[k][63] ? ((64'sd1 <<< SH_K) - 64'sd1) : 64'sd0;
      bias_d = prod[k][63] ? ((64'sd1 <<< FRAC_BITS) - 64'sd1) : 64'sd0;
      if (ctl[ST_C-1].op == OP_KICK) begin
        dlt_next[k] = (prod[k] + bias_k) >>> SH_K;
      end else begin
        dlt_next[k] = (prod[k] + bias_d) >>> FRAC_BITS;
      end
    end
  end

  // Final add with saturation; base is velocity on kick, position on drift.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      logic signed [63:0] base;
      logic signed [63:0] sum;
      base = (ctl[NST-1].op == OP_KICK) ? 64'(vel_p[NST-1][k]) : 64'(pos_p[NST-1][k]);
      sum  = base + dlt[k];
      if (sum > 64'(WORD_MAX)) begin
        sum_sat[k] = WORD_MAX;
      end else if (sum < 64'(WORD_MIN)) begin
        sum_sat[k] = WORD_MIN;
      end else begin
        sum_sat[k] = sum[WORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NST; s++) begin
        vld[s] <= 1'b0;
      end
      done <= 1'b0;
    end else begin
      vld[0] <= start && !busy;
      for (int s = 1; s < NST; s++) begin
        vld[s] <= vld[s-1];
      end
      done <= vld[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    ctl[0].op    <= opcode;
    ctl[0].zm    <= (opcode == OP_KICK) && (mass == '0);
    mass_p[0]    <= mass;
    for (int k = 0; k < LANES; k++) begin
      pos_p[0][k] <= in_pos[k];
      vel_p[0][k] <= in_vel[k];
      sgn_p[0][k] <= in_frc[k][WORD_W-1];
      rem[0][k]   <= '0;
      dq[0][k]    <= {(in_frc[k][WORD_W-1] ? WORD_W'(-in_frc[k]) : WORD_W'(in_frc[k])),
                      {FRAC_BITS{1'b0}}};
    end
    for (int s = 1; s < NST; s++) begin
      ctl[s] <= ctl[s-1];
      for (int k = 0; k < LANES; k++) begin
        pos_p[s][k] <= pos_p[s-1][k];
        vel_p[s][k] <= vel_p[s-1][k];
      end
    end
    for (int s = 1; s <= DW; s++) begin
      mass_p[s] <= mass_p[s-1];
      for (int k = 0; k < LANES; k++) begin
        sgn_p[s][k] <= sgn_p[s-1][k];
        rem[s][k]   <= rem_next[s][k];
        dq[s][k]    <= dq_next[s][k];
      end
    end
    for (int k = 0; k < LANES; k++) begin
      opa[k]  <= (ctl[ST_A-1].op == OP_KICK) ? acc_next[k] : vel_p[ST_A-1][k];
      prod[k] <= opa[k] * $signed({1'b0, time_step});
      dlt[k]  <= dlt_next[k];
    end
    zero_mass <= ctl[NST-1].zm;
    if (ctl[NST-1].op == OP_KICK) begin
      new_pos_x <= pos_p[NST-1][0];
      new_pos_y <= pos_p[NST-1][1];
      new_pos_z <= pos_p[NST-1][2];
      new_vel_x <= ctl[NST-1].zm ? vel_p[NST-1][0] : sum_sat[0];
      new_vel_y <= ctl[NST-1].zm ? vel_p[NST-1][1] : sum_sat[1];
      new_vel_z <= ctl[NST-1].zm ? vel_p[NST-1][2] : sum_sat[2];
    end else begin
      new_pos_x <= sum_sat[0];
      new_pos_y <= sum_sat[1];
      new_pos_z <= sum_sat[2];
      new_vel_x <= vel_p[NST-1][0];
      new_vel_y <= vel_p[NST-1][1];
      new_vel_z <= vel_p[NST-1][2];
    end
  end

  // Every request comes out after a fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("request did not complete after fixed latency");

  a_drift_flag: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == OP_DRIFT |-> ##LAT !zero_mass)
    else $error("zero_mass raised on drift");

  a_drift_vel: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == OP_DRIFT |-> ##LAT new_vel_x == $past(vel_x, LAT))
    else $error("drift changed velocity");

  a_kick_pos: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == OP_KICK |-> ##LAT new_pos_z == $past(pos_z, LAT))
    else $error("kick changed position");

endmodule
